@@ rtl/core/lpc_pkg.sv @@
// Shared types, constants and the arctangent table of the point converter.
package lpc_pkg;

  localparam int QUALITY_SHIFT   = 2;
  localparam int ROTATION_STAGES = 16;
  localparam int ATAN_ENTRIES    = 24;
  localparam int CORDIC_STAGES   =
    (ROTATION_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : ROTATION_STAGES;

  localparam int XW      = 37;
  localparam int ZW      = 34;
  localparam int STAGE_W = 5;
  localparam int PROD_W  = 48;

  localparam logic [29:0] GAIN_Q30    = 30'd652032874;
  localparam logic [18:0] COORD_LIMIT = 19'd262143;

  typedef logic [STAGE_W-1:0] stage_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [16:0] bearing;
    logic [17:0]        range_qmm;
    logic [5:0]         strength;
    logic               point_valid;
  } side_t;

  function automatic logic signed [ZW-1:0] atan_at(input stage_t idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:    v = 30'd536870912;
      5'd1:    v = 30'd316933406;
      5'd2:    v = 30'd167458907;
      5'd3:    v = 30'd85004756;
      5'd4:    v = 30'd42667331;
      5'd5:    v = 30'd21354465;
      5'd6:    v = 30'd10679838;
      5'd7:    v = 30'd5340245;
      5'd8:    v = 30'd2670163;
      5'd9:    v = 30'd1335087;
      5'd10:   v = 30'd667544;
      5'd11:   v = 30'd333772;
      5'd12:   v = 30'd166886;
      5'd13:   v = 30'd83443;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      default: v = 30'd0;
    endcase
    return signed'({{(ZW-30){1'b0}}, v});
  endfunction

endpackage

@@ rtl/core/lidar_point_polar_to_cartesian_core.sv @@
// Top level of the lidar point polar-to-Cartesian converter.
//
// Usage:
//   Slave channel s_*: one scan sample per beat (raw angle, distance, quality).
//   Master channel m_*: one point per beat (bearing, range, x, y, strength),
//   with the valid-point flag on m_tuser; a zero-distance sample gives an
//   all-zero point with m_tuser low.
//   An accepted beat passes one input cell, one cell per CORDIC rotation and
//   one output cell on its way to m_tvalid.
//   Throughput: one beat per cycle while m_tready stays high, set by the
//   chain of rotation cells, each holding one sample and handing it on.
//   Each cell stalls only while it is full and its successor is full and
//   stalled, so bubbles are squeezed out while the receiver holds m_tready
//   low; s_tready drops once every cell holds a sample.
//   Reset (rst, synchronous, active high) empties every cell; no sample is
//   lost or repeated across a stall.
module lidar_point_polar_to_cartesian_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // raw_angle[15:0], distance_qmm[33:16], quality_byte[41:34]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // bearing[16:0], range_qmm[34:17], x_qmm[53:35],
                                 // y_qmm[72:54], strength[78:73]
  output logic        m_tuser    // point_valid
);
  import lpc_pkg::*;

  logic  vld [CORDIC_STAGES+1];
  logic  rdy [CORDIC_STAGES+1];
  vec_t  vec [CORDIC_STAGES+1];
  side_t side [CORDIC_STAGES+1];

  lpc_prep u_prep (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .raw_angle    (s_tdata[15:0]),
    .distance_qmm (s_tdata[33:16]),
    .quality_byte (s_tdata[41:34]),
    .out_valid    (vld[0]),
    .out_ready    (rdy[0]),
    .out_vec      (vec[0]),
    .out_side     (side[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    lpc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .stage     (STAGE_W'(i)),
      .in_valid  (vld[i]),
      .in_ready  (rdy[i]),
      .in_vec    (vec[i]),
      .in_side   (side[i]),
      .out_valid (vld[i+1]),
      .out_ready (rdy[i+1]),
      .out_vec   (vec[i+1]),
      .out_side  (side[i+1])
    );
  end

  lpc_out u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld[CORDIC_STAGES]),
    .in_ready (rdy[CORDIC_STAGES]),
    .in_vec   (vec[CORDIC_STAGES]),
    .in_side  (side[CORDIC_STAGES]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

@@ rtl/core/lpc_prep.sv @@
// Input cell: angle folding, gain-scaled start vector and side fields.
module lpc_prep (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [15:0]          raw_angle,
  input  logic [17:0]          distance_qmm,
  input  logic [7:0]           quality_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lpc_pkg::vec_t        out_vec,
  output lpc_pkg::side_t       out_side
);
  import lpc_pkg::*;

  logic signed [15:0] a16;
  logic signed [16:0] a17;
  logic signed [16:0] a_adj;
  logic               flip;
  logic [PROD_W-1:0]  prod;
  logic [XW-1:0]      xpos;
  logic [7:0]         q_sh;
  vec_t               vec_next;
  side_t              side_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    a16  = signed'(16'h8000 - raw_angle);
    a17  = {a16[15], a16};
    flip = (a17 > 17'sd16384) || (a17 < -17'sd16384);
    if (!flip) begin
      a_adj = a17;
    end else if (a17 > 17'sd0) begin
      a_adj = a17 - 17'sd32768;
    end else begin
      a_adj = a17 + 17'sd32768;
    end
    prod = PROD_W'(distance_qmm) * PROD_W'(GAIN_Q30);
    xpos = {{(XW-(PROD_W-14)){1'b0}}, prod[PROD_W-1:14]};
    vec_next.x = flip ? -signed'(xpos) : signed'(xpos);
    vec_next.y = '0;
    vec_next.z = {{(ZW-33){a_adj[16]}}, a_adj, 16'b0};
    q_sh = quality_byte >> QUALITY_SHIFT;
    side_next.bearing     = signed'(17'h08000 - {1'b0, raw_angle});
    side_next.range_qmm   = distance_qmm;
    side_next.strength    = (q_sh > 8'd63) ? 6'd63 : q_sh[5:0];
    side_next.point_valid = (distance_qmm != 18'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_vec  <= vec_next;
      out_side <= side_next;
    end
  end

endmodule

@@ rtl/core/lpc_cell.sv @@
// One CORDIC rotation cell of the chain.
module lpc_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  lpc_pkg::stage_t      stage,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lpc_pkg::vec_t        in_vec,
  input  lpc_pkg::side_t       in_side,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lpc_pkg::vec_t        out_vec,
  output lpc_pkg::side_t       out_side
);
  import lpc_pkg::*;

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [ZW-1:0] at;
  vec_t                 vec_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    xs = in_vec.x >>> stage;
    ys = in_vec.y >>> stage;
    at = atan_at(stage);
    if (!in_vec.z[ZW-1]) begin
      vec_next.x = in_vec.x - ys;
      vec_next.y = in_vec.y + xs;
      vec_next.z = in_vec.z - at;
    end else begin
      vec_next.x = in_vec.x + ys;
      vec_next.y = in_vec.y - xs;
      vec_next.z = in_vec.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_vec  <= vec_next;
      out_side <= in_side;
    end
  end

endmodule

@@ rtl/core/lpc_out.sv @@
// Output cell: rounding, saturation, invalid-sample zeroing and result register.
module lpc_out (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lpc_pkg::vec_t        in_vec,
  input  lpc_pkg::side_t       in_side,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [79:0]          m_tdata,
  output logic                 m_tuser
);
  import lpc_pkg::*;

  logic signed [XW-1:0] xr;
  logic signed [XW-1:0] yr;
  logic signed [18:0]   xq;
  logic signed [18:0]   yq;
  logic [79:0]          data_next;

  function automatic logic signed [18:0] sat19(input logic signed [XW-17:0] r);
    logic signed [18:0] res;
    if (r > signed'({{(XW-35){1'b0}}, COORD_LIMIT})) begin
      res = signed'(COORD_LIMIT);
    end else if (r < -signed'({{(XW-35){1'b0}}, COORD_LIMIT})) begin
      res = -signed'(COORD_LIMIT);
    end else begin
      res = r[18:0];
    end
    return res;
  endfunction

  assign in_ready = !m_tvalid || m_tready;

  always_comb begin
    xr = in_vec.x + XW'(32768);
    yr = in_vec.y + XW'(32768);
    xq = sat19(xr[XW-1:16]);
    yq = sat19(yr[XW-1:16]);
    if (in_side.point_valid) begin
      data_next = {1'b0, in_side.strength, yq, xq, in_side.range_qmm, in_side.bearing};
    end else begin
      data_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_ready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      m_tdata <= data_next;
      m_tuser <= in_side.point_valid;
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the lidar point polar-to-Cartesian converter.
`timescale 1ns / 100ps

module tb;

  typedef struct packed {
    logic signed [16:0] bearing;
    logic [17:0]        range_q;
    logic signed [18:0] x;
    logic signed [18:0] y;
    logic [5:0]         strength;
    logic               valid;
  } point_t;

  typedef struct packed {
    logic [15:0] raw;
    logic [17:0] range_q;
    logic [7:0]  qual;
    logic        typed;
    point_t      want;
  } sample_row_t;

  localparam point_t NO_POINT = '0;
  localparam longint ROT_GAIN_Q30 = 652032874;
  localparam longint XY_LIMIT = 262143;
  localparam longint ARCTAN_TURN32 [24] = '{
    536870912, 316933406, 167458907, 85004756,
    42667331, 21354465, 10679838, 5340245,
    2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861,
    10430, 5215, 2608, 1304,
    652, 326, 163, 81
  };
  localparam int N_DIRECTED = 20;
  localparam int N_PER_PHASE = 450;

  localparam sample_row_t DIRECTED_SAMPLES [N_DIRECTED] = '{
    '{16'hFFFF, 18'd0,      8'hFF, 1'b1, NO_POINT},
    '{16'h0000, 18'd0,      8'h00, 1'b1, NO_POINT},
    '{16'h8000, 18'd0,      8'hAA, 1'b1, NO_POINT},
    '{16'h8000, 18'd262143, 8'hFF, 1'b0, NO_POINT},
    '{16'h0000, 18'd262143, 8'h00, 1'b0, NO_POINT},
    '{16'h4000, 18'd262143, 8'h03, 1'b0, NO_POINT},
    '{16'hC000, 18'd262143, 8'h04, 1'b0, NO_POINT},
    '{16'h3FFF, 18'd200000, 8'h80, 1'b0, NO_POINT},
    '{16'hC001, 18'd200000, 8'h7F, 1'b0, NO_POINT},
    '{16'h4001, 18'd1,      8'h01, 1'b0, NO_POINT},
    '{16'hBFFF, 18'd1,      8'h02, 1'b0, NO_POINT},
    '{16'hFFFF, 18'd262143, 8'hFC, 1'b0, NO_POINT},
    '{16'h0001, 18'd262143, 8'h55, 1'b0, NO_POINT},
    '{16'h6000, 18'd262143, 8'hAA, 1'b0, NO_POINT},
    '{16'hA000, 18'd12345,  8'h0F, 1'b0, NO_POINT},
    '{16'h2000, 18'd3,      8'hF0, 1'b0, NO_POINT},
    '{16'hE000, 18'd131072, 8'h33, 1'b0, NO_POINT},
    '{16'h7FFF, 18'd262142, 8'hCC, 1'b0, NO_POINT},
    '{16'h8001, 18'd2,      8'h01, 1'b0, NO_POINT},
    '{16'h1234, 18'd65535,  8'hFE, 1'b0, NO_POINT}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic        m_tuser;

  point_t pending_points [$];
  int     mismatch_count = 0;
  int     sender_idle = 25;
  int     recv_idle = 64;

  lidar_point_polar_to_cartesian_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic signed [18:0] round_coord(longint v);
    longint r;
    r = (v + 32768) >>> 16;
    if (r > XY_LIMIT) r = XY_LIMIT;
    if (r < -XY_LIMIT) r = -XY_LIMIT;
    return 19'(r);
  endfunction

  function automatic point_t polar_to_point(logic [15:0] raw, logic [17:0] range_q,
                                            logic [7:0] qual);
    point_t      p;
    logic [15:0] wrapped;
    longint      a, x, y, z, xs, ys, shifted;
    bit          flip;
    p = '0;
    if (range_q == 0) return p;
    wrapped = 16'h8000 - raw;
    a = longint'($signed(wrapped));
    flip = 1'b0;
    if (a > 16384) begin
      a -= 32768;
      flip = 1'b1;
    end else if (a < -16384) begin
      a += 32768;
      flip = 1'b1;
    end
    x = (longint'(range_q) * ROT_GAIN_Q30) >>> 14;
    if (flip) x = -x;
    y = 0;
    z = a * 65536;
    for (int i = 0; i < lpc_pkg::CORDIC_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= ARCTAN_TURN32[i];
      end else begin
        x += ys;
        y -= xs;
        z += ARCTAN_TURN32[i];
      end
    end
    shifted = longint'(qual) >> lpc_pkg::QUALITY_SHIFT;
    if (shifted > 63) shifted = 63;
    p.bearing  = 17'(32768 - longint'(raw));
    p.range_q  = range_q;
    p.x        = round_coord(x);
    p.y        = round_coord(y);
    p.strength = 6'(shifted);
    p.valid    = 1'b1;
    return p;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("%0t ns: %s mismatch, got %0d want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic put_sample(logic [15:0] raw, logic [17:0] range_q, logic [7:0] qual,
                            logic typed, point_t want);
    while ($urandom_range(99) < sender_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, qual, range_q, raw};
    do @(posedge clk); while (!s_tready);
    pending_points.push_back(typed ? want : polar_to_point(raw, range_q, qual));
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    point_t got;
    point_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.bearing  = m_tdata[16:0];
      got.range_q  = m_tdata[34:17];
      got.x        = m_tdata[53:35];
      got.y        = m_tdata[72:54];
      got.strength = m_tdata[78:73];
      got.valid    = m_tuser;
      if (pending_points.size() == 0) begin
        flag_mismatch("unexpected beat, range", longint'(got.range_q), -1);
      end else begin
        want = pending_points.pop_front();
        if (got.bearing !== want.bearing)
          flag_mismatch("bearing", longint'(got.bearing), longint'(want.bearing));
        if (got.range_q !== want.range_q)
          flag_mismatch("range", longint'(got.range_q), longint'(want.range_q));
        if (got.x !== want.x)
          flag_mismatch("x", longint'(got.x), longint'(want.x));
        if (got.y !== want.y)
          flag_mismatch("y", longint'(got.y), longint'(want.y));
        if (got.strength !== want.strength)
          flag_mismatch("strength", longint'(got.strength), longint'(want.strength));
        if (got.valid !== want.valid)
          flag_mismatch("point_valid", longint'(got.valid), longint'(want.valid));
      end
    end
  end

  initial begin
    logic [15:0] raw;
    logic [17:0] range_q;
    logic [7:0]  qual;
    int          pick;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (DIRECTED_SAMPLES[i])
      put_sample(DIRECTED_SAMPLES[i].raw, DIRECTED_SAMPLES[i].range_q,
                 DIRECTED_SAMPLES[i].qual, DIRECTED_SAMPLES[i].typed,
                 DIRECTED_SAMPLES[i].want);
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle = (phase == 0) ? 25 : (phase == 1) ? 64 : 0;
      recv_idle   = (phase == 0) ? 64 : (phase == 1) ? 25 : 0;
      for (int n = 0; n < N_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        if (pick < 5)       range_q = 18'd0;
        else if (pick < 25) range_q = 18'($urandom_range(1, 255));
        else if (pick < 35) range_q = 18'($urandom_range(262000, 262143));
        else                range_q = 18'($urandom_range(1, 262143));
        if ($urandom_range(99) < 10) begin
          case ($urandom_range(11))
            0:       raw = 16'h0000;
            1:       raw = 16'h0001;
            2:       raw = 16'h3FFF;
            3:       raw = 16'h4000;
            4:       raw = 16'h4001;
            5:       raw = 16'h7FFF;
            6:       raw = 16'h8000;
            7:       raw = 16'h8001;
            8:       raw = 16'hBFFF;
            9:       raw = 16'hC000;
            10:      raw = 16'hC001;
            default: raw = 16'hFFFF;
          endcase
        end else begin
          raw = 16'($urandom_range(0, 65535));
        end
        qual = 8'($urandom_range(0, 255));
        put_sample(raw, range_q, qual, 1'b0, NO_POINT);
      end
    end
    s_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (lpc_pkg::ROTATION_STAGES + 12) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/lpc_pkg.sv
rtl/core/lpc_prep.sv
rtl/core/lpc_cell.sv
rtl/core/lpc_out.sv
rtl/core/lidar_point_polar_to_cartesian_core.sv
tb/sv/tb.sv
